// ===== rtl/core/duet_pkg.sv =====
package duet_pkg;

  // Item kinds carried by the func field.
  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_CMD  = 1'b1
  } func_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_MAX_COUNT   = 2'd0,
    REG_PULSE_TICKS = 2'd1,
    REG_HOLD_MISSES = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_reg_t;

  // Command bytes.
  localparam logic [7:0] CMD_READ_BOTH      = 8'h01;
  localparam logic [7:0] CMD_READ_FIRST     = 8'h02;
  localparam logic [7:0] CMD_READ_SECOND    = 8'h03;
  localparam logic [7:0] CMD_NOTIFY_ENABLE  = 8'h11;
  localparam logic [7:0] CMD_NOTIFY_DISABLE = 8'h12;
  localparam logic [7:0] CMD_TEST           = 8'h55;

  // Test reply bytes, ASCII 'k' and 'o'.
  localparam logic [7:0] TEST_BYTE_ONE = 8'h6B;
  localparam logic [7:0] TEST_BYTE_TWO = 8'h6F;

  // Register values after reset.
  localparam logic [7:0] MAX_COUNT_RESET   = 8'd150;
  localparam logic [7:0] PULSE_TICKS_RESET = 8'd15;
  localparam logic [7:0] HOLD_MISSES_RESET = 8'h40;

  localparam logic [7:0] MISS_CEILING = 8'hFF;

endpackage

// ===== rtl/core/dual_ultrasonic_echo_timer.sv =====
// Dual ultrasonic echo timer. Every input beat is either a time tick
// (func = 0) or a received command byte (func = 1), and every accepted beat
// yields exactly one result beat in the next cycle, so the block sustains one
// beat per clock; the only thing that can hold it back is a stalled result
// register, since the input is stalled only while a finished result is
// waiting and the downstream side stalls it. The two channels are measured
// in turn: a tick that finds no measurement under way raises the active
// channel's trigger and clears the tick count, and each tick with the echo
// high and the count below max_count adds one; the trigger falls once the
// count passes pulse_ticks. A low echo or the limit ends the measurement,
// latching the length or counting a miss (more than hold_misses misses in a
// row clear the latched length), and the other channel becomes active.
// Command beats return latched lengths or the test bytes 'k','o', or switch
// notify on or off; they never advance a measurement. The configuration
// registers are written through wr_en, wr_index and wr_data and should only
// be changed while no beat is in flight; indexes outside the list are ignored.
module dual_ultrasonic_echo_timer (
  input  logic       clk,
  input  logic       rst,

  // Configuration write port.
  input  logic       wr_en,
  input  logic [1:0] wr_index,
  input  logic [7:0] wr_data,

  // Input channel.
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       func,
  input  logic       echo_first,
  input  logic       echo_second,
  input  logic [7:0] command_byte,

  // Result channel.
  output logic       out_valid,
  input  logic       out_stall,
  output logic       trig_first,
  output logic       trig_second,
  output logic [7:0] length_first,
  output logic [7:0] length_second,
  output logic       notify,
  output logic [1:0] reply_count,
  output logic [7:0] reply_one,
  output logic [7:0] reply_two
);

  // Configuration registers.
  logic [7:0] max_count;
  logic [7:0] pulse_ticks;
  logic [7:0] hold_misses;

  // Measurement state.
  logic       active_channel, active_channel_next;
  logic       measuring, measuring_next;
  logic [7:0] tick_count, tick_count_next;
  logic       trigger_on, trigger_on_next;
  logic [7:0] miss_count [2];
  logic [7:0] miss_count_next [2];
  logic [7:0] latched_length [2];
  logic [7:0] latched_length_next [2];
  logic       notify_enabled, notify_enabled_next;

  // Reply of the current beat.
  logic [1:0] reply_count_next;
  logic [7:0] reply_one_next;
  logic [7:0] reply_two_next;

  logic       accept;

  // Working values of one tick.
  logic       echo;
  logic [7:0] count_start;
  logic       trigger_start;
  logic [7:0] count_inc;
  logic [7:0] miss_inc;

  // The result register is the only buffer: take a beat whenever it is
  // empty or is being emptied in this cycle.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_count   <= duet_pkg::MAX_COUNT_RESET;
      pulse_ticks <= duet_pkg::PULSE_TICKS_RESET;
      hold_misses <= duet_pkg::HOLD_MISSES_RESET;
    end else if (wr_en) begin
      unique case (duet_pkg::cfg_reg_t'(wr_index))
        duet_pkg::REG_MAX_COUNT:   max_count   <= wr_data;
        duet_pkg::REG_PULSE_TICKS: pulse_ticks <= wr_data;
        duet_pkg::REG_HOLD_MISSES: hold_misses <= wr_data;
        default: ;
      endcase
    end
  end

  // A tick that finds no measurement under way starts one and evaluates the
  // echo within the same tick.
  assign echo          = active_channel ? echo_second : echo_first;
  assign count_start   = measuring ? tick_count : 8'd0;
  assign trigger_start = measuring ? trigger_on : 1'b1;
  assign count_inc     = count_start + 8'd1;
  assign miss_inc      = (miss_count[active_channel] == duet_pkg::MISS_CEILING) ?
                         miss_count[active_channel] :
                         miss_count[active_channel] + 8'd1;

  always_comb begin
    active_channel_next    = active_channel;
    measuring_next         = measuring;
    tick_count_next        = tick_count;
    trigger_on_next        = trigger_on;
    miss_count_next[0]     = miss_count[0];
    miss_count_next[1]     = miss_count[1];
    latched_length_next[0] = latched_length[0];
    latched_length_next[1] = latched_length[1];
    notify_enabled_next    = notify_enabled;
    reply_count_next       = 2'd0;
    reply_one_next         = 8'd0;
    reply_two_next         = 8'd0;

    if (func == duet_pkg::FUNC_TICK) begin
      if (echo && (count_start < max_count)) begin
        measuring_next  = 1'b1;
        tick_count_next = count_inc;
        trigger_on_next = trigger_start && !(count_inc > pulse_ticks);
      end else begin
        // End of measurement: latch a length or count a miss.
        if (count_start < max_count) begin
          miss_count_next[active_channel]     = 8'd0;
          latched_length_next[active_channel] = count_start;
        end else if (miss_inc > hold_misses) begin
          miss_count_next[active_channel]     = 8'd0;
          latched_length_next[active_channel] = 8'd0;
        end else begin
          miss_count_next[active_channel] = miss_inc;
        end
        measuring_next      = 1'b0;
        tick_count_next     = count_start;
        trigger_on_next     = 1'b0;
        active_channel_next = !active_channel;
      end
    end else begin
      unique case (command_byte)
        duet_pkg::CMD_READ_BOTH: begin
          reply_count_next = 2'd2;
          reply_one_next   = latched_length[0];
          reply_two_next   = latched_length[1];
        end
        duet_pkg::CMD_READ_FIRST: begin
          reply_count_next = 2'd1;
          reply_one_next   = latched_length[0];
        end
        duet_pkg::CMD_READ_SECOND: begin
          reply_count_next = 2'd1;
          reply_one_next   = latched_length[1];
        end
        duet_pkg::CMD_TEST: begin
          reply_count_next = 2'd2;
          reply_one_next   = duet_pkg::TEST_BYTE_ONE;
          reply_two_next   = duet_pkg::TEST_BYTE_TWO;
        end
        duet_pkg::CMD_NOTIFY_ENABLE:  notify_enabled_next = 1'b1;
        duet_pkg::CMD_NOTIFY_DISABLE: notify_enabled_next = 1'b0;
        default: ;
      endcase
    end
  end

  // State advances only on an accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_channel    <= 1'b0;
      measuring         <= 1'b0;
      tick_count        <= 8'd0;
      trigger_on        <= 1'b0;
      miss_count[0]     <= 8'd0;
      miss_count[1]     <= 8'd0;
      latched_length[0] <= 8'd0;
      latched_length[1] <= 8'd0;
      notify_enabled    <= 1'b0;
    end else if (accept) begin
      active_channel    <= active_channel_next;
      measuring         <= measuring_next;
      tick_count        <= tick_count_next;
      trigger_on        <= trigger_on_next;
      miss_count[0]     <= miss_count_next[0];
      miss_count[1]     <= miss_count_next[1];
      latched_length[0] <= latched_length_next[0];
      latched_length[1] <= latched_length_next[1];
      notify_enabled    <= notify_enabled_next;
    end
  end

  // Result register: holds the values after the update of the beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      trig_first    <= trigger_on_next && !active_channel_next;
      trig_second   <= trigger_on_next && active_channel_next;
      length_first  <= latched_length_next[0];
      length_second <= latched_length_next[1];
      notify        <= notify_enabled_next &&
                       ((latched_length_next[0] != 8'd0) ||
                        (latched_length_next[1] != 8'd0));
      reply_count   <= reply_count_next;
      reply_one     <= reply_one_next;
      reply_two     <= reply_two_next;
    end
  end

  // Only one channel is ever triggered.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(trig_first && trig_second))
    else $error("both triggers high");

  // The trigger is only on during a measurement.
  assert property (@(posedge clk) disable iff (rst)
    !measuring |-> !trigger_on)
    else $error("trigger on with no measurement under way");

  // Notify needs a nonzero latched length.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && notify) |-> ((length_first != 8'd0) || (length_second != 8'd0)))
    else $error("notify with both lengths zero");

  // A tick beat produces a result with no reply bytes.
  assert property (@(posedge clk) disable iff (rst)
    (accept && (func == duet_pkg::FUNC_TICK)) |=> (out_valid && (reply_count == 2'd0)))
    else $error("tick beat produced a reply");

endmodule

// ===== tb/dual_ultrasonic_echo_timer_tb.sv =====
module dual_ultrasonic_echo_timer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // SETTLE_CYCLES quiet cycles after the last result are enough to catch a
  // stray extra result. The watchdog limit sits far above the long receiver
  // hold-off.
  localparam int SETTLE_CYCLES    = 4;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT   = 2000;

  logic       clk;
  logic       rst;
  logic       wr_en;
  logic [1:0] wr_index;
  logic [7:0] wr_data;
  logic       in_valid;
  logic       in_stall;
  logic       func;
  logic       echo_first;
  logic       echo_second;
  logic [7:0] command_byte;
  logic       out_valid;
  logic       out_stall;
  logic       trig_first;
  logic       trig_second;
  logic [7:0] length_first;
  logic [7:0] length_second;
  logic       notify;
  logic [1:0] reply_count;
  logic [7:0] reply_one;
  logic [7:0] reply_two;

  dual_ultrasonic_echo_timer dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Timer predictor. It mirrors the block's registers and measurement state and
  // turns every accepted beat into the one result beat that the block must
  // produce, with all fields taken after the beat's update.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic       trig_first;
    logic       trig_second;
    logic [7:0] length_first;
    logic [7:0] length_second;
    logic       notify;
    logic [1:0] reply_count;
    logic [7:0] reply_one;
    logic [7:0] reply_two;
  } echo_reading_t;

  echo_reading_t pending_readings[$];

  logic [7:0] cfg_limit = duet_pkg::MAX_COUNT_RESET;
  logic [7:0] cfg_pulse = duet_pkg::PULSE_TICKS_RESET;
  logic [7:0] cfg_hold  = duet_pkg::HOLD_MISSES_RESET;

  bit         side      = 1'b0;  // channel being measured, 0 is the first one
  bit         timing    = 1'b0;  // a measurement is under way
  bit         trig_high = 1'b0;
  bit         notify_on = 1'b0;
  logic [7:0] ticks     = 8'd0;
  logic [7:0] misses [2]  = '{8'd0, 8'd0};
  logic [7:0] lengths [2] = '{8'd0, 8'd0};

  function automatic void predict_echo_timer(duet_pkg::func_t kind, logic e1, logic e2,
                                             logic [7:0] cmd);
    echo_reading_t r;
    logic          echo;
    r = '{default: '0};
    if (kind == duet_pkg::FUNC_TICK) begin
      echo = side ? e2 : e1;
      // A tick that finds the timer idle starts a measurement and still
      // looks at the echo in the same tick.
      if (!timing) begin
        timing    = 1'b1;
        ticks     = 8'd0;
        trig_high = 1'b1;
      end
      if (echo && ticks < cfg_limit) begin
        ticks++;
        if (trig_high && ticks > cfg_pulse)
          trig_high = 1'b0;
      end else begin
        if (ticks < cfg_limit) begin
          misses[side]  = 8'd0;
          lengths[side] = ticks;
        end else begin
          // The miss count saturates, so with a hold of 255 misses never
          // clear the latched length.
          if (misses[side] != duet_pkg::MISS_CEILING)
            misses[side]++;
          if (misses[side] > cfg_hold) begin
            lengths[side] = 8'd0;
            misses[side]  = 8'd0;
          end
        end
        trig_high = 1'b0;
        timing    = 1'b0;
        side      = ~side;
      end
    end else begin
      case (cmd)
        duet_pkg::CMD_READ_BOTH: begin
          r.reply_count = 2'd2;
          r.reply_one   = lengths[0];
          r.reply_two   = lengths[1];
        end
        duet_pkg::CMD_READ_FIRST: begin
          r.reply_count = 2'd1;
          r.reply_one   = lengths[0];
        end
        duet_pkg::CMD_READ_SECOND: begin
          r.reply_count = 2'd1;
          r.reply_one   = lengths[1];
        end
        duet_pkg::CMD_TEST: begin
          r.reply_count = 2'd2;
          r.reply_one   = duet_pkg::TEST_BYTE_ONE;
          r.reply_two   = duet_pkg::TEST_BYTE_TWO;
        end
        duet_pkg::CMD_NOTIFY_ENABLE:  notify_on = 1'b1;
        duet_pkg::CMD_NOTIFY_DISABLE: notify_on = 1'b0;
        default: ;
      endcase
    end
    r.trig_first    = trig_high && !side;
    r.trig_second   = trig_high && side;
    r.length_first  = lengths[0];
    r.length_second = lengths[1];
    r.notify        = notify_on && (lengths[0] != 8'd0 || lengths[1] != 8'd0);
    pending_readings.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking. Every result beat is held against the oldest prediction;
  // a beat with nothing pending counts as a failure as well.
  // ---------------------------------------------------------------------------
  int mismatches = 0;

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    echo_reading_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        $error("result beat arrived with no prediction pending");
        mismatches++;
      end else begin
        want = pending_readings.pop_front();
        check_field("trig_first", 8'(want.trig_first), 8'(trig_first));
        check_field("trig_second", 8'(want.trig_second), 8'(trig_second));
        check_field("length_first", want.length_first, length_first);
        check_field("length_second", want.length_second, length_second);
        check_field("notify", 8'(want.notify), 8'(notify));
        check_field("reply_count", 8'(want.reply_count), 8'(reply_count));
        check_field("reply_one", want.reply_one, reply_one);
        check_field("reply_two", want.reply_two, reply_two);
      end
    end
  end

  // The watchdog ends a hung run: it counts cycles in which neither channel
  // moves a beat.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("dual_ultrasonic_echo_timer_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. It stalls on a pattern of its own: it switches between stretches
  // of no stalls, light and heavy stalling, each stretch of random length.
  // When the backpressure test asks, it holds the result channel off for a
  // long stretch so that the block fills and stalls its input.
  // ---------------------------------------------------------------------------
  bit long_hold_req = 1'b0;

  initial begin : receiver
    int stall_pct;
    int mode_left;
    out_stall <= 1'b0;
    stall_pct = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(32, 200);
        case ($urandom_range(0, 4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 25;
          3:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      mode_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. A beat is offered until the block takes it, and the prediction is
  // made at that edge. Valid stays high from one beat to the next inside a
  // burst; between bursts the sender drops valid for a random gap, unless the
  // running test has turned gaps off.
  // ---------------------------------------------------------------------------
  int burst_left  = 0;
  bit sender_gaps = 1'b1;

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = sender_gaps ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_beat(duet_pkg::func_t kind, logic e1, logic e2, logic [7:0] cmd);
    in_valid     <= 1'b1;
    func         <= kind;
    echo_first   <= e1;
    echo_second  <= e2;
    command_byte <= cmd;
    do @(posedge clk); while (in_stall);
    predict_echo_timer(kind, e1, e2, cmd);
    pace_sender();
  endtask

  // A tick that drives the echo of the channel now being measured; the other
  // echo and the command byte carry noise that the block must ignore.
  task automatic send_tick(logic active_echo);
    logic other;
    other = 1'($urandom_range(0, 1));
    if (side)
      send_beat(duet_pkg::FUNC_TICK, other, active_echo, 8'($urandom_range(0, 255)));
    else
      send_beat(duet_pkg::FUNC_TICK, active_echo, other, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_noise_tick();
    send_beat(duet_pkg::FUNC_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              8'($urandom_range(0, 255)));
  endtask

  // Command beats carry random echo levels, which the block must ignore.
  task automatic send_command(logic [7:0] cmd);
    send_beat(duet_pkg::FUNC_CMD, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), cmd);
  endtask

  function automatic logic [7:0] pick_command();
    logic [7:0] raw;
    raw = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 6))
      0:       return duet_pkg::CMD_READ_BOTH;
      1:       return duet_pkg::CMD_READ_FIRST;
      2:       return duet_pkg::CMD_READ_SECOND;
      3:       return duet_pkg::CMD_NOTIFY_ENABLE;
      4:       return duet_pkg::CMD_NOTIFY_DISABLE;
      5:       return duet_pkg::CMD_TEST;
      default: return raw;
    endcase
  endfunction

  // Waits until every predicted result has come back. Each beat yields exactly
  // one result, so an empty store means the block is idle.
  task automatic wait_for_results();
    if (in_valid)
      in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(duet_pkg::cfg_reg_t idx, logic [7:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    case (idx)
      duet_pkg::REG_MAX_COUNT:   cfg_limit = data;
      duet_pkg::REG_PULSE_TICKS: cfg_pulse = data;
      duet_pkg::REG_HOLD_MISSES: cfg_hold  = data;
      default: ;
    endcase
  endtask

  // Rewrites all registers, plus a write to the unused index that the block
  // must ignore. Only done once the block has gone idle.
  task automatic configure(logic [7:0] lim, logic [7:0] pulse, logic [7:0] hold);
    wait_for_results();
    write_reg(duet_pkg::REG_MAX_COUNT, lim);
    write_reg(duet_pkg::REG_PULSE_TICKS, pulse);
    write_reg(duet_pkg::REG_HOLD_MISSES, hold);
    write_reg(duet_pkg::REG_UNUSED, 8'($urandom_range(0, 255)));
    wr_en <= 1'b0;
  endtask

  // Ends a measurement left open by an earlier test so that a directed
  // sequence starts from an idle timer.
  task automatic finish_measurement();
    if (timing)
      send_tick(1'b0);
  endtask

  // Mostly well-formed echo pulses of random width on whichever channel is
  // active, with commands and pure noise ticks mixed in. Widths stay short
  // when the limit is large, with an occasional pulse that runs to the limit.
  task automatic run_echo_pulses(int beats);
    int sent;
    int roll;
    int width;
    int top;
    sent = 0;
    while (sent < beats) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        send_command(pick_command());
        sent++;
      end else if (roll < 20) begin
        send_noise_tick();
        sent++;
      end else begin
        top = int'(cfg_limit) + 1;
        if (top > 25 && $urandom_range(0, 19) != 0)
          width = $urandom_range(0, 24);
        else
          width = $urandom_range(0, top);
        repeat (width) begin
          if ($urandom_range(0, 15) == 0) begin
            send_command(pick_command());
            sent++;
          end
          send_tick(1'b1);
          sent++;
        end
        send_tick(1'b0);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Every command straight after reset: lengths read back as zero, the test
  // bytes come back, unknown bytes at both ends of the range do nothing.
  task automatic test_commands_after_reset();
    send_command(duet_pkg::CMD_READ_BOTH);
    send_command(duet_pkg::CMD_READ_FIRST);
    send_command(duet_pkg::CMD_READ_SECOND);
    send_command(duet_pkg::CMD_TEST);
    send_command(duet_pkg::CMD_NOTIFY_ENABLE);
    send_command(8'h00);
    send_command(8'hFF);
    send_command(duet_pkg::CMD_NOTIFY_DISABLE);
  endtask

  // Random pulses with the registers still at their reset values.
  task automatic test_reset_settings();
    sender_gaps = 1'b1;
    run_echo_pulses(150);
  endtask

  // Hand-built measurements with a limit of three, a one-tick trigger pulse
  // and no misses tolerated.
  task automatic test_directed_measurement();
    configure(8'd3, 8'd1, 8'd0);
    finish_measurement();
    if (side)
      send_tick(1'b0);
    // Channel one: the trigger stays up on the start tick and falls on the
    // next, then a low echo latches a length of two.
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_command(duet_pkg::CMD_NOTIFY_ENABLE);
    // Channel two latches a length of one.
    send_tick(1'b1);
    send_tick(1'b0);
    send_command(duet_pkg::CMD_READ_BOTH);
    // A start tick with the echo already low latches zero on channel one.
    send_tick(1'b0);
    // Channel two runs into the limit; with no misses tolerated its length
    // is cleared at once.
    repeat (4) send_tick(1'b1);
    send_command(duet_pkg::CMD_READ_SECOND);
    send_command(duet_pkg::CMD_NOTIFY_DISABLE);
  endtask

  // With a zero limit every measurement ends as a miss on its start tick.
  task automatic test_zero_limit();
    configure(8'd0, 8'd0, 8'd2);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_command(duet_pkg::CMD_READ_BOTH);
  endtask

  // Several register settings, the extremes among them; some phases run with
  // back-to-back beats and no sender gaps.
  task automatic test_random_settings();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       configure(8'd255, 8'd255, 8'd254);
        1:       configure(8'd1, 8'd0, 8'd0);
        5:       configure(8'd8, 8'd255, 8'd3);
        default: configure(8'($urandom_range(2, 30)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 10)));
      endcase
      sender_gaps = (phase % 3) != 2;
      run_echo_pulses(120);
    end
    sender_gaps = 1'b1;
  endtask

  // Latches a length on both channels, then drives well over 255 misses per
  // channel with a zero limit and a hold of 255: the miss count saturates and
  // the lengths survive. Dropping the hold to 254 lets the next miss clear.
  task automatic test_miss_ceiling();
    configure(8'd5, 8'd0, 8'd255);
    finish_measurement();
    repeat (2) begin
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
    end
    configure(8'd0, 8'd0, 8'd255);
    repeat (600) begin
      if ($urandom_range(0, 19) == 0)
        send_command(pick_command());
      else
        send_noise_tick();
    end
    configure(8'd0, 8'd0, 8'd254);
    repeat (4) send_noise_tick();
    send_command(duet_pkg::CMD_READ_BOTH);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // beats with no gaps, so the block fills up and stalls its input.
  task automatic test_backpressure();
    configure(8'd20, 8'd4, 8'd5);
    sender_gaps   = 1'b0;
    long_hold_req = 1'b1;
    run_echo_pulses(40);
    sender_gaps   = 1'b1;
  endtask

  initial begin
    rst          <= 1'b1;
    wr_en        <= 1'b0;
    wr_index     <= duet_pkg::REG_MAX_COUNT;
    wr_data      <= 8'd0;
    in_valid     <= 1'b0;
    func         <= duet_pkg::FUNC_TICK;
    echo_first   <= 1'b0;
    echo_second  <= 1'b0;
    command_byte <= 8'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_commands_after_reset();
    test_reset_settings();
    test_directed_measurement();
    test_zero_limit();
    test_random_settings();
    test_miss_ceiling();
    test_backpressure();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("dual_ultrasonic_echo_timer_tb: clean");
    else
      $display("dual_ultrasonic_echo_timer_tb: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/duet_pkg.sv
rtl/core/dual_ultrasonic_echo_timer.sv
tb/dual_ultrasonic_echo_timer_tb.sv
